// ===== rtl/grid_ray_boundary_step_core_defines.svh =====
// Assertion macros shared by the grid ray boundary step RTL.
// Included by the top level; no other dependencies.
`ifndef GRID_RAY_BOUNDARY_STEP_CORE_DEFINES_SVH
`define GRID_RAY_BOUNDARY_STEP_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define GRBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grbs assertion failed");

// next-cycle implication, disabled during reset
`define GRBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grbs assertion failed");

`endif

// ===== rtl/grbs_pkg.sv =====
// Shared types and constants for the grid ray boundary step core.
// No dependencies.
`timescale 1ns / 1ps
package grbs_pkg;

  localparam int POS_W         = 32;
  localparam int DIR_W         = 32;
  localparam int BND_W         = 34;
  localparam int MAG_W         = 33;
  localparam int CELL_W        = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 1;
  localparam int IN_W          = 64;
  localparam int OUT_W         = 96;
  localparam int USER_W        = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RAY_DIR_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RAY_DIR_Y = 1'b1;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7fffffff;
  localparam logic signed [POS_W-1:0] POS_MIN = 32'sh80000000;

  typedef struct packed {
    logic signed [DIR_W-1:0] d;
    logic signed [POS_W-1:0] p;
    logic signed [BND_W-1:0] b;
  } axis_side_t;

  typedef struct packed {
    logic signed [POS_W-1:0] next_x;
    logic signed [POS_W-1:0] next_y;
    logic                    axis;
    logic                    zero;
    logic                    dec_x;
    logic                    dec_y;
  } step_res_t;

endpackage

// ===== rtl/grbs_front.sv =====
// Front stages: nudge, grid boundary and divider operands for both axes.
// Depends on grbs_pkg.
`timescale 1ns / 1ps
module grbs_front #(
  parameter int FRAC_BITS = grbs_pkg::FRAC_BITS_DEF,
  parameter int NUM_W     = grbs_pkg::MAG_W + FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [grbs_pkg::POS_W-1:0]  pos_x,
  input  logic signed [grbs_pkg::POS_W-1:0]  pos_y,
  input  logic signed [grbs_pkg::DIR_W-1:0]  dir_x,
  input  logic signed [grbs_pkg::DIR_W-1:0]  dir_y,
  output logic                               out_valid,
  output grbs_pkg::axis_side_t               out_side_x,
  output grbs_pkg::axis_side_t               out_side_y,
  output logic [NUM_W-1:0]                   out_num_x,
  output logic [NUM_W-1:0]                   out_num_y,
  output logic [grbs_pkg::DIR_W-1:0]         out_den_x,
  output logic [grbs_pkg::DIR_W-1:0]         out_den_y
);
  import grbs_pkg::*;

  localparam logic signed [BND_W-1:0] ONE_M1 = (BND_W'(1) << FRAC_BITS) - BND_W'(1);
  localparam logic [BND_W-1:0]        FMASK  = ~((BND_W'(1) << FRAC_BITS) - BND_W'(1));

  logic signed [POS_W-1:0] pos_a [2];
  logic signed [DIR_W-1:0] dir_a [2];

  logic                    v1_r;
  axis_side_t              side1_r [2];
  axis_side_t              side1_nxt [2];
  logic [DIR_W-1:0]        den1_r [2];
  logic [DIR_W-1:0]        den1_nxt [2];

  logic                    v2_r;
  axis_side_t              side2_r [2];
  logic [NUM_W-1:0]        num2_r [2];
  logic [NUM_W-1:0]        num2_nxt [2];
  logic [DIR_W-1:0]        den2_r [2];

  assign pos_a[0] = pos_x;
  assign pos_a[1] = pos_y;
  assign dir_a[0] = dir_x;
  assign dir_a[1] = dir_y;

  // boundary: round p + nudge + neg up to a grid line
  always_comb begin
    logic signed [BND_W-1:0] k;
    logic signed [BND_W-1:0] sum;
    for (int i = 0; i < 2; i++) begin
      k   = dir_a[i][DIR_W-1] ? '1 : ONE_M1;
      sum = BND_W'(pos_a[i]) + BND_W'(dir_a[i] >>> FRAC_BITS) + k;
      side1_nxt[i].d = dir_a[i];
      side1_nxt[i].p = pos_a[i];
      side1_nxt[i].b = sum & FMASK;
      den1_nxt[i]    = dir_a[i][DIR_W-1] ? DIR_W'(-dir_a[i]) : DIR_W'(dir_a[i]);
    end
  end

  // distance to the boundary as a magnitude, scaled by one
  always_comb begin
    logic signed [BND_W-1:0] mag;
    for (int i = 0; i < 2; i++) begin
      mag = side1_r[i].d[DIR_W-1] ? (BND_W'(side1_r[i].p) - side1_r[i].b)
                                  : (side1_r[i].b - BND_W'(side1_r[i].p));
      num2_nxt[i] = {mag[MAG_W-1:0], {FRAC_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        side1_r[i] <= side1_nxt[i];
        den1_r[i]  <= den1_nxt[i];
        side2_r[i] <= side1_r[i];
        num2_r[i]  <= num2_nxt[i];
        den2_r[i]  <= den1_r[i];
      end
    end
  end

  assign out_valid  = v2_r;
  assign out_side_x = side2_r[0];
  assign out_side_y = side2_r[1];
  assign out_num_x  = num2_r[0];
  assign out_num_y  = num2_r[1];
  assign out_den_x  = den2_r[0];
  assign out_den_y  = den2_r[1];

endmodule

// ===== rtl/grbs_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on grbs_pkg.
`timescale 1ns / 1ps
module grbs_div #(
  parameter int NUM_W = grbs_pkg::MAG_W + grbs_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [NUM_W-1:0]            in_num,
  input  logic [grbs_pkg::DIR_W-1:0]  in_den,
  input  grbs_pkg::axis_side_t        in_side,
  output logic                        out_valid,
  output logic [NUM_W-1:0]            out_quo,
  output grbs_pkg::axis_side_t        out_side
);
  import grbs_pkg::*;

  logic             vld_r  [NUM_W];
  logic [DIR_W-1:0] rem_r  [NUM_W];
  logic [NUM_W-1:0] num_r  [NUM_W];
  logic [DIR_W-1:0] den_r  [NUM_W];
  axis_side_t       side_r [NUM_W];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic             vld_in;
    logic [DIR_W-1:0] rem_in;
    logic [NUM_W-1:0] num_in;
    logic [DIR_W-1:0] den_in;
    axis_side_t       side_in;
    logic [DIR_W:0]   shf;
    logic             ge;
    logic [DIR_W-1:0] rem_nxt;
    logic [NUM_W-1:0] num_nxt;

    if (s == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = '0;
      assign num_in  = in_num;
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign num_in  = num_r[s-1];
      assign den_in  = den_r[s-1];
      assign side_in = side_r[s-1];
    end

    always_comb begin
      logic [DIR_W:0] dif;
      shf     = {rem_in, num_in[NUM_W-1]};
      dif     = shf - {1'b0, den_in};
      ge      = (shf >= {1'b0, den_in});
      rem_nxt = ge ? dif[DIR_W-1:0] : shf[DIR_W-1:0];
      num_nxt = {num_in[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        num_r[s]  <= num_nxt;
        den_r[s]  <= den_in;
        side_r[s] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[NUM_W-1];
  assign out_quo   = num_r[NUM_W-1];
  assign out_side  = side_r[NUM_W-1];

endmodule

// ===== rtl/grbs_back.sv =====
// Back stages: axis select, split multiply, move and saturate.
// Depends on grbs_pkg.
`timescale 1ns / 1ps
module grbs_back #(
  parameter int FRAC_BITS = grbs_pkg::FRAC_BITS_DEF,
  parameter int QUO_W     = grbs_pkg::MAG_W + FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [QUO_W-1:0]      tq_x,
  input  logic [QUO_W-1:0]      tq_y,
  input  grbs_pkg::axis_side_t  side_x,
  input  grbs_pkg::axis_side_t  side_y,
  output logic                  out_valid,
  output grbs_pkg::step_res_t   out_res
);
  import grbs_pkg::*;

  localparam int LO_W = QUO_W / 2;
  localparam int HI_W = QUO_W - LO_W;
  localparam int PL_W = DIR_W + LO_W + 1;
  localparam int PH_W = DIR_W + HI_W + 1;
  localparam int PR_W = DIR_W + QUO_W + 1;
  localparam int MV_W = PR_W - FRAC_BITS + 1;

  // stage 1: pick the nearer crossing
  logic                    v1_r, zero1_r, axis1_r, dn1_r;
  logic [QUO_W-1:0]        tm1_r;
  logic signed [POS_W-1:0] po1_r;
  logic signed [DIR_W-1:0] do1_r;
  logic signed [BND_W-1:0] bc1_r;
  logic                    zero1_nxt, axis1_nxt;

  always_comb begin
    logic vx, vy;
    vx        = (side_x.d != '0);
    vy        = (side_y.d != '0);
    zero1_nxt = !vx && !vy;
    axis1_nxt = (vx && (!vy || (tq_x < tq_y))) ? AXIS_X : AXIS_Y;
  end

  // stage 2: direction times parameter as two partial products
  logic                    v2_r, zero2_r, axis2_r, dn2_r;
  logic signed [PL_W-1:0]  pl2_r;
  logic signed [PH_W-1:0]  ph2_r;
  logic signed [POS_W-1:0] po2_r;
  logic signed [BND_W-1:0] bc2_r;
  logic signed [PL_W-1:0]  pl2_nxt;
  logic signed [PH_W-1:0]  ph2_nxt;

  assign pl2_nxt = do1_r * $signed({1'b0, tm1_r[LO_W-1:0]});
  assign ph2_nxt = do1_r * $signed({1'b0, tm1_r[QUO_W-1:LO_W]});

  // stage 3: combine partials and move the other axis
  logic                    v3_r, zero3_r, axis3_r, dn3_r;
  logic signed [MV_W-1:0]  mv3_r;
  logic signed [BND_W-1:0] bc3_r;
  logic signed [MV_W-1:0]  mv3_nxt;

  always_comb begin
    logic signed [PR_W-1:0] prod;
    prod    = (PR_W'(ph2_r) <<< LO_W) + PR_W'(pl2_r);
    mv3_nxt = MV_W'(po2_r) + MV_W'(prod >>> FRAC_BITS);
  end

  // stage 4: saturate and place on x and y
  logic      v4_r;
  step_res_t res4_r;
  step_res_t res4_nxt;

  always_comb begin
    logic signed [POS_W-1:0] so, sc;
    logic                    ovo, ovc;
    ovo = !((&mv3_r[MV_W-1:POS_W-1]) || !(|mv3_r[MV_W-1:POS_W-1]));
    ovc = !((&bc3_r[BND_W-1:POS_W-1]) || !(|bc3_r[BND_W-1:POS_W-1]));
    so  = ovo ? (mv3_r[MV_W-1] ? POS_MIN : POS_MAX) : mv3_r[POS_W-1:0];
    sc  = ovc ? (bc3_r[BND_W-1] ? POS_MIN : POS_MAX) : bc3_r[POS_W-1:0];
    res4_nxt.next_x = (axis3_r == AXIS_X) ? sc : so;
    res4_nxt.next_y = (axis3_r == AXIS_X) ? so : sc;
    res4_nxt.axis   = axis3_r;
    res4_nxt.zero   = zero3_r;
    res4_nxt.dec_x  = (axis3_r == AXIS_X) && dn3_r;
    res4_nxt.dec_y  = (axis3_r == AXIS_Y) && dn3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero1_r <= zero1_nxt;
      axis1_r <= axis1_nxt;
      tm1_r   <= (axis1_nxt == AXIS_X) ? tq_x : tq_y;
      po1_r   <= (axis1_nxt == AXIS_X) ? side_y.p : side_x.p;
      do1_r   <= (axis1_nxt == AXIS_X) ? side_y.d : side_x.d;
      bc1_r   <= (axis1_nxt == AXIS_X) ? side_x.b : side_y.b;
      dn1_r   <= (axis1_nxt == AXIS_X) ? side_x.d[DIR_W-1] : side_y.d[DIR_W-1];
      zero2_r <= zero1_r;
      axis2_r <= axis1_r;
      dn2_r   <= dn1_r;
      pl2_r   <= pl2_nxt;
      ph2_r   <= ph2_nxt;
      po2_r   <= po1_r;
      bc2_r   <= bc1_r;
      zero3_r <= zero2_r;
      axis3_r <= axis2_r;
      dn3_r   <= dn2_r;
      mv3_r   <= mv3_nxt;
      bc3_r   <= bc2_r;
      res4_r  <= res4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_res   = res4_r;

endmodule

// ===== rtl/grid_ray_boundary_step_core.sv =====
// Top level of the grid ray boundary step core: direction registers,
// front, two dividers, back and output register.
// Depends on grbs_pkg, grbs_front, grbs_div, grbs_back and the defines header.
//
// Usage:
//   Write ray_dir_x (index 0) and ray_dir_y (index 1) on the cfg port while
//   no transaction is in flight. Each in_ transaction carries one point,
//   pos_x in tdata[31:0] and pos_y in tdata[63:32]. Each point yields one
//   out_ transaction: the point on the next grid crossing, the cell
//   entered, the crossed axis and the zero-direction flag.
//   A point passes through the front, the bit-per-stage dividers, the back
//   and the output register; one transaction per cycle is sustained while
//   the receiver does not stall.
//   Reset clears the direction registers to zero and empties the pipeline.
//   When the receiver stalls, the output register holds its result and the
//   pipeline keeps advancing into empty slots; in_tready drops only once the
//   last stage holds a result behind the stalled output.
`timescale 1ns / 1ps
`include "grid_ray_boundary_step_core_defines.svh"
module grid_ray_boundary_step_core #(
  parameter int FRAC_BITS = grbs_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [grbs_pkg::IN_W-1:0]          in_tdata,   // pos_x, pos_y
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [grbs_pkg::OUT_W-1:0]         out_tdata,  // next_x, next_y, cell_x, cell_y
  output logic [grbs_pkg::USER_W-1:0]        out_tuser,  // crossed_axis, dir_zero
  input  logic                               cfg_we,
  input  logic [grbs_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [grbs_pkg::DIR_W-1:0]         cfg_wdata
);
  import grbs_pkg::*;

  localparam int NUM_W = MAG_W + FRAC_BITS;
  localparam int CEW   = ((POS_W + 1 - FRAC_BITS) > (CELL_W + 1)) ?
                         (POS_W + 1 - FRAC_BITS) : (CELL_W + 1);

  logic signed [DIR_W-1:0] ray_dir_x_r, ray_dir_y_r;

  logic             en, out_load, last_valid;
  logic             fr_valid;
  axis_side_t       fr_side_x, fr_side_y;
  logic [NUM_W-1:0] fr_num_x, fr_num_y;
  logic [DIR_W-1:0] fr_den_x, fr_den_y;
  logic             div_valid_x, div_valid_y;
  logic [NUM_W-1:0] quo_x, quo_y;
  axis_side_t       dv_side_x, dv_side_y;
  step_res_t        res;

  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;
  logic [USER_W-1:0] out_user_r, out_user_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ray_dir_x_r <= '0;
      ray_dir_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_RAY_DIR_X: ray_dir_x_r <= cfg_wdata;
        REG_RAY_DIR_Y: ray_dir_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_load  = !out_valid_r || out_tready;
  assign en        = out_load || !last_valid;
  assign in_tready = en;

  grbs_front #(.FRAC_BITS(FRAC_BITS), .NUM_W(NUM_W)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_tvalid),
    .pos_x      (in_tdata[POS_W-1:0]),
    .pos_y      (in_tdata[2*POS_W-1:POS_W]),
    .dir_x      (ray_dir_x_r),
    .dir_y      (ray_dir_y_r),
    .out_valid  (fr_valid),
    .out_side_x (fr_side_x),
    .out_side_y (fr_side_y),
    .out_num_x  (fr_num_x),
    .out_num_y  (fr_num_y),
    .out_den_x  (fr_den_x),
    .out_den_y  (fr_den_y)
  );

  grbs_div #(.NUM_W(NUM_W)) u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .in_num    (fr_num_x),
    .in_den    (fr_den_x),
    .in_side   (fr_side_x),
    .out_valid (div_valid_x),
    .out_quo   (quo_x),
    .out_side  (dv_side_x)
  );

  grbs_div #(.NUM_W(NUM_W)) u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .in_num    (fr_num_y),
    .in_den    (fr_den_y),
    .in_side   (fr_side_y),
    .out_valid (div_valid_y),
    .out_quo   (quo_y),
    .out_side  (dv_side_y)
  );

  grbs_back #(.FRAC_BITS(FRAC_BITS), .QUO_W(NUM_W)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (div_valid_x),
    .tq_x      (quo_x),
    .tq_y      (quo_y),
    .side_x    (dv_side_x),
    .side_y    (dv_side_y),
    .out_valid (last_valid),
    .out_res   (res)
  );

  // cell index: floor of the point, one less on a crossed negative axis
  always_comb begin
    logic [CEW-1:0]    cx, cy;
    logic [CELL_W-1:0] scx, scy;
    cx  = CEW'($signed(res.next_x) >>> FRAC_BITS) - CEW'(res.dec_x);
    cy  = CEW'($signed(res.next_y) >>> FRAC_BITS) - CEW'(res.dec_y);
    scx = ((&cx[CEW-1:CELL_W-1]) || !(|cx[CEW-1:CELL_W-1])) ? cx[CELL_W-1:0] :
          (cx[CEW-1] ? {1'b1, {(CELL_W-1){1'b0}}} : {1'b0, {(CELL_W-1){1'b1}}});
    scy = ((&cy[CEW-1:CELL_W-1]) || !(|cy[CEW-1:CELL_W-1])) ? cy[CELL_W-1:0] :
          (cy[CEW-1] ? {1'b1, {(CELL_W-1){1'b0}}} : {1'b0, {(CELL_W-1){1'b1}}});
    if (res.zero) begin
      out_data_nxt = '0;
      out_user_nxt = {1'b1, AXIS_X};
    end else begin
      out_data_nxt = {scy, scx, res.next_y, res.next_x};
      out_user_nxt = {1'b0, res.axis};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && last_valid) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `GRBS_ASSERT_IMP(a_lane_sync, clk, rst_n, 1'b1, div_valid_x == div_valid_y)
  `GRBS_ASSERT_IMP(a_ready_follows_sink, clk, rst_n, out_tready, in_tready)
  `GRBS_ASSERT_NXT(a_result_lands, clk, rst_n, last_valid && en, out_tvalid)
  `GRBS_ASSERT_IMP(a_zero_clean, clk, rst_n, out_tvalid && out_tuser[1], (out_tdata == '0) && !out_tuser[0])

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for grid_ray_boundary_step_core: random and directed
// points under several ray directions, checked against a built-in step predictor.
// Depends on grbs_pkg and the core RTL.
`timescale 1ns / 1ps
module testbench;
  import grbs_pkg::*;

  localparam int FB = 16;
  localparam longint ONE = 64'sd1 << FB;
  localparam int LAT = FB + 40;
  localparam longint LIMIT = 4000000;

  typedef struct {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic axis;
    logic zero;
  } step_t;

  class step_board;
    longint dir_x, dir_y;
    step_t pending[$];
    int errors;
    int checked;

    function longint floor_shift(longint v);
      if (v >= 0) return v >>> FB;
      return -(((-v) - 1) >>> FB) - 1;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void note_point(logic signed [31:0] px32, logic signed [31:0] py32);
      longint px, py, bx, by, tx, ty, tm, nx, ny, cx, cy, nq;
      step_t r;
      bit ax;
      px = px32;
      py = py32;
      nq = dir_x < 0 ? -ONE : 0;
      bx = floor_shift(px + floor_shift(dir_x) + nq + ONE - 1) * ONE;
      tx = dir_x != 0 ? ((bx - px) * ONE) / dir_x : 0;
      nq = dir_y < 0 ? -ONE : 0;
      by = floor_shift(py + floor_shift(dir_y) + nq + ONE - 1) * ONE;
      ty = dir_y != 0 ? ((by - py) * ONE) / dir_y : 0;
      r = '{default: '0};
      if (dir_x == 0 && dir_y == 0) begin
        r.zero = 1'b1;
      end else begin
        ax = (dir_x != 0 && (dir_y == 0 || tx < ty)) ? AXIS_X : AXIS_Y;
        tm = ax == AXIS_X ? tx : ty;
        if (ax == AXIS_X) begin
          nx = bx;
          ny = py + floor_shift(dir_y * tm);
        end else begin
          ny = by;
          nx = px + floor_shift(dir_x * tm);
        end
        nx = clamp(nx, -64'sd2147483648, 64'sd2147483647);
        ny = clamp(ny, -64'sd2147483648, 64'sd2147483647);
        cx = floor_shift(nx);
        cy = floor_shift(ny);
        if (ax == AXIS_X && dir_x < 0) cx -= 1;
        if (ax == AXIS_Y && dir_y < 0) cy -= 1;
        r.nx = 32'(nx);
        r.ny = 32'(ny);
        r.cx = 16'(clamp(cx, -32768, 32767));
        r.cy = 16'(clamp(cy, -32768, 32767));
        r.axis = ax;
      end
      pending.push_back(r);
    endfunction

    function void check_step(logic [95:0] d, logic [1:0] u);
      step_t e;
      step_t a;
      a.nx = d[31:0];
      a.ny = d[63:32];
      a.cx = d[79:64];
      a.cy = d[95:80];
      a.axis = u[0];
      a.zero = u[1];
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h %h", $time, d, u);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (a.nx !== e.nx || a.ny !== e.ny || a.cx !== e.cx || a.cy !== e.cy ||
          a.axis !== e.axis || a.zero !== e.zero) begin
        $display("%0t: mismatch exp nx=%0d ny=%0d cx=%0d cy=%0d ax=%0b z=%0b",
                 $time, e.nx, e.ny, e.cx, e.cy, e.axis, e.zero);
        $display("%0t:          act nx=%0d ny=%0d cx=%0d cy=%0d ax=%0b z=%0b",
                 $time, a.nx, a.ny, a.cx, a.cy, a.axis, a.zero);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [USER_W-1:0] out_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [DIR_W-1:0] cfg_wdata = '0;

  step_board board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycles = 0;
  int sent = 0;

  always #5 clk = ~clk;

  grid_ray_boundary_step_core u_dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_step(out_tdata, out_tuser);
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_dir(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_RAY_DIR_X) board.dir_x = $signed(val);
    else board.dir_y = $signed(val);
  endtask

  task automatic wait_empty();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  task automatic drain();
    wait_empty();
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic set_dir(logic [31:0] dx, logic [31:0] dy);
    drain();
    write_dir(REG_RAY_DIR_X, dx);
    write_dir(REG_RAY_DIR_Y, dy);
    cfg_we <= 1'b0;
  endtask

  task automatic send_point(logic [31:0] px, logic [31:0] py);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {py, px};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_point(px, py);
    sent++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return {16'($urandom_range(15) - 8), 16'h0000};
      2: return $signed($urandom_range(2000000)) - 1000000;
      default: return {16'($urandom()), 16'h0} | ($urandom_range(1) ? 32'h0 : $urandom_range(3));
    endcase
  endfunction

  function automatic logic [31:0] rand_dir();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return $urandom();
      2: return $urandom_range(65535);
      3: return -$urandom_range(65535);
      4: return $signed($urandom_range(400000)) - 200000;
      default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  initial begin
    logic [31:0] dirs[8][2];
    logic [31:0] edge_pts[6];
    int ph;
    dirs = '{'{32'h0, 32'h0}, '{32'h10000, 32'h10000}, '{32'hffff0000, 32'h8000},
             '{32'h7fffffff, 32'h80000000}, '{32'h80000000, 32'h0},
             '{32'h0, 32'h7fffffff}, '{32'h1, 32'hffffffff}, '{32'h18000, 32'hfffe8000}};
    edge_pts = '{32'h0, 32'h7fffffff, 32'h80000000, 32'h10000, 32'hffff0000, 32'h8000};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extreme points under extreme and tie-producing directions
    for (int d = 0; d < 4; d++) begin
      set_dir(dirs[d][0], dirs[d][1]);
      for (int i = 0; i < 6; i++) send_point(edge_pts[i], edge_pts[5 - i]);
    end
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      for (int blk = 0; blk < 8; blk++) begin
        if (blk < 4) set_dir(dirs[(ph * 4 + blk) % 8][0], dirs[(ph * 4 + blk) % 8][1]);
        else set_dir(rand_dir(), rand_dir());
        for (int i = 0; i < 50; i++) send_point(rand_coord(), rand_coord());
        // hold off until the pipeline is empty
        if (blk == 3) wait_empty();
      end
    end
    drain();
    $display("Sent %0d points over 36 direction settings, %0d results checked.",
             sent, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/grbs_pkg.sv
rtl/grbs_front.sv
rtl/grbs_div.sv
rtl/grbs_back.sv
rtl/grid_ray_boundary_step_core.sv
tb/sv/testbench.sv
